### design/qrs_pkg.sv
// shared constants and types of the quadratic root solver
`default_nettype none
package qrs_pkg;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int EPS_W          = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  typedef enum logic [1:0] {
    CNT_ZERO = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } cnt_t;

  typedef struct packed {
    cnt_t cnt;
    logic den_neg;
  } front_ctl_t;
endpackage
`default_nettype wire

### design/qrs_if.sv
// request, configuration and result channels of the quadratic root solver
`default_nettype none
interface qrs_in_if #(parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [qrs_pkg::EPS_W-1:0]   eps_threshold;
  modport source (output valid, eps_threshold, input ready);
  modport sink (input valid, eps_threshold, output ready);
endinterface

interface qrs_out_if #(parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   root_count;
  logic signed [COEF_WIDTH-1:0] first_root;
  logic                         first_valid;
  logic signed [COEF_WIDTH-1:0] second_root;
  logic                         second_valid;
  logic                         saturated;
  modport source (output valid, root_count, first_root, first_valid, second_root,
                  second_valid, saturated, input ready);
  modport sink (input valid, root_count, first_root, first_valid, second_root,
                second_valid, saturated, output ready);
endinterface
`default_nettype wire

### design/quadratic_root_solver_top.sv
// top level of the quadratic root solver
//
//  channel  dir  payload                                   handshake
//  in_ch    in   coef_a, coef_b, coef_c                    valid / ready
//  cfg_ch   in   eps_threshold                             valid / ready (always ready)
//  out_ch   out  root_count, roots, valid bits, saturated  valid / ready
//
//  one request per cycle while the output register is empty or taken
//  stages in order: front, square root, numerator, divide, output
//  the square root and divider chains set the latency, one bit per stage
//  all stages move together while the output register is empty or taken
//  synchronous active-low reset clears the valid bits, eps_threshold to 1
`default_nettype none
module quadratic_root_solver_top #(
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qrs_in_if.sink     in_ch,
  qrs_cfg_if.sink    cfg_ch,
  qrs_out_if.source  out_ch
);
  localparam int W      = COEF_WIDTH;
  localparam int RW     = W + 1;
  localparam int DW     = 2 * W + 2;
  localparam int NSW    = W + 3;
  localparam int NW     = NSW + FRAC_BITS;
  localparam int SQ_SW  = 3 + (W + 1) + (W + 1);
  localparam logic [NW-1:0] LIM_POS = NW'((64'(1) << (W - 1)) - 64'(1));
  localparam logic [NW-1:0] LIM_NEG = NW'(64'(1) << (W - 1));

  logic [qrs_pkg::EPS_W-1:0] eps_r;
  logic en;
  logic out_valid_r;
  logic [1:0] count_r;
  logic [W-1:0] first_r, second_r;
  logic first_valid_r, second_valid_r, sat_r;

  logic                fr_valid;
  qrs_pkg::front_ctl_t fr_ctl;
  logic signed [W:0]   fr_base;
  logic [W:0]          fr_den;
  logic [DW-1:0]       fr_disc;

  logic                sq_valid;
  logic [RW-1:0]       sq_root;
  logic [SQ_SW-1:0]    sq_side_in, sq_side;
  qrs_pkg::front_ctl_t sq_ctl;
  logic signed [W:0]   sq_base;
  logic [W:0]          sq_den;

  logic                  nm_valid_r;
  qrs_pkg::front_ctl_t   nm_ctl_r;
  logic signed [NSW-1:0] num1_r, num2_r;
  logic [W:0]            nm_den_r;
  logic signed [NSW-1:0] bx, sx;

  logic          d1_valid, d2_valid, d1_neg, d2_neg;
  logic [NW-1:0] d1_quo, d2_quo;
  logic [1:0]    d1_side, d2_side;

  logic [NW-1:0] lim1, lim2, qc1, qc2;
  logic          sat1, sat2;
  logic [W-1:0]  r1, r2;
  qrs_pkg::cnt_t fin_cnt;
  logic [1:0]    count_nxt;
  logic [W-1:0]  first_nxt, second_nxt;
  logic          first_valid_nxt, second_valid_nxt, sat_nxt;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= qrs_pkg::EPS_RESET;
    end else if (cfg_ch.valid) begin
      eps_r <= cfg_ch.eps_threshold;
    end
  end

  qrs_front #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .eps(eps_r),
    .in_valid(in_ch.valid), .in_a(in_ch.coef_a), .in_b(in_ch.coef_b), .in_c(in_ch.coef_c),
    .out_valid(fr_valid), .out_ctl(fr_ctl), .out_base(fr_base), .out_den(fr_den),
    .out_disc(fr_disc)
  );

  assign sq_side_in = {fr_ctl, fr_base, fr_den};

  qrs_sqrt #(.RW(RW), .SIDE_W(SQ_SW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(fr_valid), .in_rad(fr_disc), .in_side(sq_side_in),
    .out_valid(sq_valid), .out_root(sq_root), .out_side(sq_side)
  );

  assign {sq_ctl, sq_base, sq_den} = sq_side;
  assign bx = {{2{sq_base[W]}}, sq_base};
  assign sx = $signed({2'b00, sq_root});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_valid_r <= 1'b0;
    end else if (en) begin
      nm_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_ctl_r <= sq_ctl;
      nm_den_r <= sq_den;
      num1_r   <= (sq_ctl.cnt == qrs_pkg::CNT_TWO) ? (bx - sx) : bx;
      num2_r   <= bx + sx;
    end
  end

  qrs_div #(.NSW(NSW), .DENW(W + 1), .FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_div1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(nm_valid_r),
    .in_num(num1_r), .in_den(nm_den_r), .in_den_neg(nm_ctl_r.den_neg),
    .in_side(nm_ctl_r.cnt),
    .out_valid(d1_valid), .out_quo(d1_quo), .out_neg(d1_neg), .out_side(d1_side)
  );

  qrs_div #(.NSW(NSW), .DENW(W + 1), .FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_div2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(nm_valid_r),
    .in_num(num2_r), .in_den(nm_den_r), .in_den_neg(nm_ctl_r.den_neg),
    .in_side(nm_ctl_r.cnt),
    .out_valid(d2_valid), .out_quo(d2_quo), .out_neg(d2_neg), .out_side(d2_side)
  );

  always_comb begin
    fin_cnt = qrs_pkg::cnt_t'(d1_side);
    lim1 = d1_neg ? LIM_NEG : LIM_POS;
    lim2 = d2_neg ? LIM_NEG : LIM_POS;
    sat1 = d1_quo > lim1;
    sat2 = d2_quo > lim2;
    qc1  = sat1 ? lim1 : d1_quo;
    qc2  = sat2 ? lim2 : d2_quo;
    r1   = d1_neg ? (W'(0) - W'(qc1)) : W'(qc1);
    r2   = d2_neg ? (W'(0) - W'(qc2)) : W'(qc2);
    count_nxt        = d1_side;
    first_nxt        = '0;
    second_nxt       = '0;
    first_valid_nxt  = 1'b0;
    second_valid_nxt = 1'b0;
    sat_nxt          = 1'b0;
    case (fin_cnt)
      qrs_pkg::CNT_ONE: begin
        first_nxt       = r1;
        first_valid_nxt = 1'b1;
        sat_nxt         = sat1;
      end
      qrs_pkg::CNT_TWO: begin
        first_nxt       = r1;
        first_valid_nxt = 1'b1;
        sat_nxt         = sat1 || (sat2 && (d2_side == qrs_pkg::CNT_TWO));
        if (d2_side == qrs_pkg::CNT_TWO) begin
          second_nxt       = r2;
          second_valid_nxt = 1'b1;
        end
      end
      default: begin
        first_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d1_valid && d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      count_r        <= count_nxt;
      first_r        <= first_nxt;
      second_r       <= second_nxt;
      first_valid_r  <= first_valid_nxt;
      second_valid_r <= second_valid_nxt;
      sat_r          <= sat_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.root_count   = count_r;
  assign out_ch.first_root   = first_r;
  assign out_ch.first_valid  = first_valid_r;
  assign out_ch.second_root  = second_r;
  assign out_ch.second_valid = second_valid_r;
  assign out_ch.saturated    = sat_r;

  a_two_both_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (count_r == qrs_pkg::CNT_TWO) |-> first_valid_r && second_valid_r)
    else $error("two roots without both valid bits");

  a_sat_needs_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |-> first_valid_r)
    else $error("saturation without a root");

  a_empty_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !first_valid_r |-> (first_r == '0) && (second_r == '0))
    else $error("root field set without a root");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    d1_valid == d2_valid)
    else $error("divider lanes out of step");
endmodule
`default_nettype wire

### design/qrs_front.sv
// front stages: magnitudes, products, discriminant and classification
`default_nettype none
module qrs_front #(
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic [qrs_pkg::EPS_W-1:0]      eps,
  input  wire logic                           in_valid,
  input  wire logic [COEF_WIDTH-1:0]          in_a,
  input  wire logic [COEF_WIDTH-1:0]          in_b,
  input  wire logic [COEF_WIDTH-1:0]          in_c,
  output logic                                out_valid,
  output qrs_pkg::front_ctl_t                 out_ctl,
  output logic signed [COEF_WIDTH:0]          out_base,
  output logic [COEF_WIDTH:0]                 out_den,
  output logic [2*COEF_WIDTH+1:0]             out_disc
);
  localparam int W   = COEF_WIDTH;
  localparam int DW  = 2 * W + 2;
  localparam int TWD = qrs_pkg::EPS_W + FRAC_BITS + 1;
  localparam int CW  = (DW > TWD) ? DW : TWD;

  logic         v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [W-1:0] a1_r, b1_r, c1_r;
  logic         an2_r, bn2_r, cn2_r, sa2_r, sb2_r, sc2_r;
  logic [W-1:0] am2_r, bm2_r, cm2_r;
  logic         an3_r, bn3_r, cn3_r, sa3_r, sb3_r, sc3_r;
  logic [W-1:0] am3_r, bm3_r, cm3_r;
  logic [2*W-1:0] bb3_r, ac3_r;
  logic         an4_r, bn4_r, cn4_r, sa4_r, sb4_r, sc4_r;
  logic [W-1:0] am4_r, bm4_r, cm4_r;
  logic signed [DW-1:0] d4_r;
  qrs_pkg::front_ctl_t ctl5_r;
  logic signed [W:0] base5_r;
  logic [W:0]        den5_r;
  logic [DW-1:0]     disc5_r;

  logic [W-1:0] am_nxt, bm_nxt, cm_nxt;
  logic [DW-1:0] bbx, acx;
  logic signed [DW-1:0] d_nxt;
  logic signed [CW-1:0] dx, tolx;
  logic near;
  qrs_pkg::front_ctl_t ctl_nxt;
  logic signed [W:0] base_nxt;
  logic [W:0]        den_nxt;

  always_comb begin
    am_nxt = a1_r[W-1] ? (W'(0) - a1_r) : a1_r;
    bm_nxt = b1_r[W-1] ? (W'(0) - b1_r) : b1_r;
    cm_nxt = c1_r[W-1] ? (W'(0) - c1_r) : c1_r;
    bbx    = {2'b00, bb3_r};
    acx    = {ac3_r, 2'b00};
    d_nxt  = (an3_r ^ cn3_r) ? $signed(bbx + acx) : $signed(bbx - acx);
    dx     = CW'(d4_r);
    tolx   = $signed(CW'({eps, FRAC_BITS'(0)}));
    near   = (dx < tolx) && (dx > -tolx);
    ctl_nxt  = '{cnt: qrs_pkg::CNT_ZERO, den_neg: 1'b0};
    base_nxt = '0;
    den_nxt  = '0;
    if (sa4_r) begin
      base_nxt = cn4_r ? $signed({1'b0, cm4_r}) : -$signed({1'b0, cm4_r});
      den_nxt  = {1'b0, bm4_r};
      ctl_nxt.den_neg = bn4_r;
      if (sb4_r) begin
        ctl_nxt.cnt = sc4_r ? qrs_pkg::CNT_INF : qrs_pkg::CNT_ZERO;
      end else begin
        ctl_nxt.cnt = qrs_pkg::CNT_ONE;
      end
    end else begin
      base_nxt = bn4_r ? $signed({1'b0, bm4_r}) : -$signed({1'b0, bm4_r});
      den_nxt  = {am4_r, 1'b0};
      ctl_nxt.den_neg = an4_r;
      if (near) begin
        ctl_nxt.cnt = qrs_pkg::CNT_ONE;
      end else if (d4_r[DW-1]) begin
        ctl_nxt.cnt = qrs_pkg::CNT_ZERO;
      end else begin
        ctl_nxt.cnt = qrs_pkg::CNT_TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= in_a;
      b1_r  <= in_b;
      c1_r  <= in_c;
      an2_r <= a1_r[W-1];
      bn2_r <= b1_r[W-1];
      cn2_r <= c1_r[W-1];
      am2_r <= am_nxt;
      bm2_r <= bm_nxt;
      cm2_r <= cm_nxt;
      sa2_r <= (am_nxt == '0) || (am_nxt < W'(eps));
      sb2_r <= (bm_nxt == '0) || (bm_nxt < W'(eps));
      sc2_r <= (cm_nxt == '0) || (cm_nxt < W'(eps));
      an3_r <= an2_r;
      bn3_r <= bn2_r;
      cn3_r <= cn2_r;
      sa3_r <= sa2_r;
      sb3_r <= sb2_r;
      sc3_r <= sc2_r;
      am3_r <= am2_r;
      bm3_r <= bm2_r;
      cm3_r <= cm2_r;
      bb3_r <= bm2_r * bm2_r;
      ac3_r <= am2_r * cm2_r;
      an4_r <= an3_r;
      bn4_r <= bn3_r;
      cn4_r <= cn3_r;
      sa4_r <= sa3_r;
      sb4_r <= sb3_r;
      sc4_r <= sc3_r;
      am4_r <= am3_r;
      bm4_r <= bm3_r;
      cm4_r <= cm3_r;
      d4_r  <= d_nxt;
      ctl5_r  <= ctl_nxt;
      base5_r <= base_nxt;
      den5_r  <= den_nxt;
      disc5_r <= d4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_ctl   = ctl5_r;
  assign out_base  = base5_r;
  assign out_den   = den5_r;
  assign out_disc  = disc5_r;
endmodule
`default_nettype wire

### design/qrs_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module qrs_sqrt #(
  parameter int RW     = qrs_pkg::COEF_WIDTH_DEF + 1,
  parameter int SIDE_W = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [2*RW-1:0]     in_rad,
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     out_valid,
  output logic [RW-1:0]            out_root,
  output logic [SIDE_W-1:0]        out_side
);
  localparam int DW = 2 * RW;

  logic [RW:0]     vld_r;
  logic [RW+1:0]   rem_r   [RW+1];
  logic [RW-1:0]   root_r  [RW+1];
  logic [DW-1:0]   rad_r   [RW+1];
  logic [SIDE_W-1:0] side_r [RW+1];
  logic [RW+1:0]   rem_nxt [RW+1];
  logic [RW-1:0]   root_nxt[RW+1];
  logic [DW-1:0]   rad_nxt [RW+1];
  logic [RW+1:0]   rsh     [RW];
  logic [RW+1:0]   trial   [RW];
  logic [RW-1:0]   ge;

  always_comb begin
    rem_nxt[0]  = '0;
    root_nxt[0] = '0;
    rad_nxt[0]  = in_rad;
    for (int k = 0; k < RW; k++) begin
      rsh[k]   = {rem_r[k][RW-1:0], rad_r[k][DW-1 -: 2]};
      trial[k] = {root_r[k], 2'b01};
      ge[k]    = rsh[k] >= trial[k];
      rem_nxt[k+1]  = ge[k] ? (rsh[k] - trial[k]) : rsh[k];
      root_nxt[k+1] = {root_r[k][RW-2:0], ge[k]};
      rad_nxt[k+1]  = {rad_r[k][DW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 0; k <= RW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
      end
      for (int k = 0; k < RW; k++) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[RW];
  assign out_root  = root_r[RW];
  assign out_side  = side_r[RW];
endmodule
`default_nettype wire

### design/qrs_div.sv
// pipelined restoring divider with fraction shift, one quotient bit per stage
`default_nettype none
module qrs_div #(
  parameter int NSW       = qrs_pkg::COEF_WIDTH_DEF + 3,
  parameter int DENW      = qrs_pkg::COEF_WIDTH_DEF + 1,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic signed [NSW-1:0]  in_num,
  input  wire logic [DENW-1:0]        in_den,
  input  wire logic                   in_den_neg,
  input  wire logic [SIDE_W-1:0]      in_side,
  output logic                        out_valid,
  output logic [NSW+FRAC_BITS-1:0]    out_quo,
  output logic                        out_neg,
  output logic [SIDE_W-1:0]           out_side
);
  localparam int NW = NSW + FRAC_BITS;

  logic [NW:0]       vld_r;
  logic [NW-1:0]     nq_r   [NW+1];
  logic [DENW-1:0]   rem_r  [NW+1];
  logic [DENW-1:0]   den_r  [NW+1];
  logic              neg_r  [NW+1];
  logic [SIDE_W-1:0] side_r [NW+1];
  logic [NW-1:0]     nq_nxt [NW+1];
  logic [DENW-1:0]   rem_nxt[NW+1];
  logic [DENW:0]     rsh    [NW];
  logic [NW-1:0]     ge;
  logic [NSW-1:0]    mag;

  always_comb begin
    mag        = in_num[NSW-1] ? (NSW'(0) - NSW'(in_num)) : NSW'(in_num);
    nq_nxt[0]  = {mag, FRAC_BITS'(0)};
    rem_nxt[0] = '0;
    for (int k = 0; k < NW; k++) begin
      rsh[k] = {rem_r[k], nq_r[k][NW-1]};
      ge[k]  = rsh[k] >= {1'b0, den_r[k]};
      rem_nxt[k+1] = ge[k] ? DENW'(rsh[k] - {1'b0, den_r[k]}) : DENW'(rsh[k]);
      nq_nxt[k+1]  = {nq_r[k][NW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= in_den;
      neg_r[0]  <= in_num[NSW-1] ^ in_den_neg;
      side_r[0] <= in_side;
      for (int k = 0; k <= NW; k++) begin
        nq_r[k]  <= nq_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
      for (int k = 0; k < NW; k++) begin
        den_r[k+1]  <= den_r[k];
        neg_r[k+1]  <= neg_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[NW];
  assign out_quo   = nq_r[NW];
  assign out_neg   = neg_r[NW];
  assign out_side  = side_r[NW];
endmodule
`default_nettype wire
